// ----- rtl/midpoint_ellipse_rasterizer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the midpoint ellipse rasterizer
// Implication and next-cycle implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_ASSERT_SVH

// same-cycle implication
`define MER_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MER_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared widths, command codes, pixel-set modes and the emitter control bundle.
// ----------------------------------------------------------------------------
package mer_pkg;

	// decision variable width (wraps modulo 2^DEC_W)
	localparam int DEC_W     = 56;
	localparam int PIX_W     = 14;
	localparam int COLOR_W   = 24;
	localparam int M_TDATA_W = ((2 * PIX_W + COLOR_W + 7) / 8) * 8;

	// input command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// pixel set kinds handed to the emitter
	typedef enum logic [1:0] {
		EM_VERT  = 2'd0,  // top and bottom pixels of a start
		EM_FOUR  = 2'd1,  // four mirror pixels of a step
		EM_HORIZ = 2'd2   // right and left pixels ending the ellipse
	} mode_t;

	typedef struct packed {
		logic  load;
		mode_t mode;
	} emit_ctl_t;

endpackage

// ----- rtl/midpoint_ellipse_rasterizer_top.sv -----
// Start: squares the axes and seeds the decision; first pixel in the cycle after hand-off.
// Step: in region one a region test, then one or two decision updates; in region two one or
// two updates; the switch seeds region two; the closing pair hands off directly; idle step:
// no pixels. Hand-off waits while pixels still stream. All products use one shared multiplier;
// pixels leave one per cycle unless stalled, overlapping the next transaction's arithmetic.
// Reset (arst_n low, asynchronous): no ellipse open, color 0, output empty.
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer, top level
// Stream wrapper: input unpacking, color register, sequencer and emitter.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top #(
	parameter int AXIS_BITS  = 11,
	parameter int COORD_BITS = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// center_x, center_y, semi_axis_x, semi_axis_y (lowest bits first), zero pad
	input  logic [((2*COORD_BITS+2*AXIS_BITS+7)/8)*8-1:0] s_axis_tdata,
	// cmd
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// pixel_x, pixel_y, pixel_color (lowest bits first), zero pad
	output logic [mer_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// last
	output logic                           m_axis_tlast,
	// done_res
	output logic                           m_axis_tuser,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mer_pkg::COLOR_W-1:0]    cfg_data
);
	import mer_pkg::*;

	localparam int PT_W = AXIS_BITS + 1;

	logic [COLOR_W-1:0]    color_q;
	logic [COORD_BITS-1:0] cx_in;
	logic [COORD_BITS-1:0] cy_in;
	logic [AXIS_BITS-1:0]  ax_in;
	logic [AXIS_BITS-1:0]  ay_in;
	emit_ctl_t             emit_ctl;
	logic                  emit_busy;
	logic [COORD_BITS-1:0] cx;
	logic [COORD_BITS-1:0] cy;
	logic [PT_W-1:0]       ox;
	logic [PT_W-1:0]       oy;

	// input field unpacking
	assign cx_in = s_axis_tdata[COORD_BITS-1:0];
	assign cy_in = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign ax_in = s_axis_tdata[2*COORD_BITS+AXIS_BITS-1:2*COORD_BITS];
	assign ay_in = s_axis_tdata[2*COORD_BITS+2*AXIS_BITS-1:2*COORD_BITS+AXIS_BITS];

	// color register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			color_q <= cfg_data;
		end
	end

	mer_seq #(
		.AXIS_BITS  (AXIS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_mer_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cmd       (s_axis_tuser),
		.cx_in     (cx_in),
		.cy_in     (cy_in),
		.ax_in     (ax_in),
		.ay_in     (ay_in),
		.emit_busy (emit_busy),
		.emit_ctl  (emit_ctl),
		.cx        (cx),
		.cy        (cy),
		.ox        (ox),
		.oy        (oy)
	);

	mer_emit #(
		.COORD_BITS (COORD_BITS),
		.PT_W       (PT_W)
	) u_mer_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (emit_ctl),
		.cx            (cx),
		.cy            (cy),
		.ox            (ox),
		.oy            (oy),
		.color         (color_q),
		.busy          (emit_busy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

// ----- rtl/mer_mul.sv -----
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned by signed product with a registered result, one product per enable.
// ----------------------------------------------------------------------------
module mer_mul #(
	parameter int A_W = 22,
	parameter int B_W = 27
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [A_W-1:0]           a_op,
	input  logic signed [B_W-1:0]    b_op,
	output logic signed [A_W+B_W:0]  prod_q
);

	// product register; operand a is always non-negative
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= $signed({1'b0, a_op}) * b_op;
		end
	end

endmodule

// ----- rtl/mer_seq.sv -----
// ----------------------------------------------------------------------------
// Ellipse sequencer
// Holds the point, decision and axis squares, and walks each transaction
// through a list of multiply/accumulate ops on the shared multiplier.
// ----------------------------------------------------------------------------
module mer_seq #(
	parameter int AXIS_BITS  = 11,
	parameter int COORD_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     cmd,
	input  logic [COORD_BITS-1:0]    cx_in,
	input  logic [COORD_BITS-1:0]    cy_in,
	input  logic [AXIS_BITS-1:0]     ax_in,
	input  logic [AXIS_BITS-1:0]     ay_in,
	input  logic                     emit_busy,
	output mer_pkg::emit_ctl_t       emit_ctl,
	output logic [COORD_BITS-1:0]    cx,
	output logic [COORD_BITS-1:0]    cy,
	output logic [AXIS_BITS:0]       ox,
	output logic [AXIS_BITS:0]       oy
);
	import mer_pkg::*;

	localparam int PT_W  = AXIS_BITS + 1;
	localparam int SQ_W  = 2 * AXIS_BITS;
	localparam int B_W   = 2 * AXIS_BITS + 5;
	localparam int P_W   = SQ_W + 1 + B_W;
	localparam int EXT_W = (P_W > DEC_W) ? P_W : DEC_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_ACC  = 4'b0100,
		S_HAND = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_R1   = 3'b010,
		PH_R2   = 3'b100
	} phase_t;

	// multiply/accumulate ops
	typedef enum logic [3:0] {
		OP_AA,   // a*a
		OP_BB,   // b*b, D = 4bb + aa
		OP_AB,   // D -= 4*aa*b
		OP_T1L,  // 2*bb*(x+1)
		OP_T1R,  // aa*(2y-1), region one test
		OP_R1X,  // D += 4*bb*(2x+3)
		OP_R1Y,  // D += 4*aa*(2-2y)
		OP_TX,   // (2x+1)^2
		OP_E1,   // D = bb*(2x+1)^2
		OP_TY,   // (y-1)^2
		OP_E2,   // D += 4*aa*(y-1)^2
		OP_E3,   // D -= 4*aa*bb
		OP_R2Y,  // D += 4*aa*(3-2y)
		OP_R2X   // D += 4*bb*(2x+2)
	} op_t;

	state_t               state_q;
	phase_t               phase_q;
	op_t                  op_q;
	mode_t                mode_q;
	logic [PT_W-1:0]      px_q;
	logic [PT_W-1:0]      py_q;
	logic [DEC_W-1:0]     dec_q;
	logic [DEC_W-1:0]     t_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [AXIS_BITS-1:0] a0_q;
	logic [SQ_W-1:0]      aa_q;
	logic [SQ_W-1:0]      bb_q;

	logic [SQ_W-1:0]         a_op;
	logic signed [B_W-1:0]   b_op;
	logic signed [P_W-1:0]   prod;
	logic signed [EXT_W-1:0] p_ext;
	logic [DEC_W-1:0]        p_dec;
	logic [DEC_W-1:0]        p4;
	logic [B_W-1:0]          bpx;
	logic [B_W-1:0]          bpy;
	logic [PT_W:0]           tx;
	logic [PT_W-1:0]         ty;
	logic                    dec_neg;

	mer_mul #(
		.A_W (SQ_W),
		.B_W (B_W)
	) u_mer_mul (
		.clk    (clk),
		.en     (state_q == S_MUL),
		.a_op   (a_op),
		.b_op   (b_op),
		.prod_q (prod)
	);

	// product folded into the decision width
	assign p_ext   = EXT_W'(prod);
	assign p_dec   = p_ext[DEC_W-1:0];
	assign p4      = {p_dec[DEC_W-3:0], 2'b00};
	assign dec_neg = dec_q[DEC_W-1];

	// operand select per op
	always_comb begin
		bpx = B_W'(px_q);
		bpy = B_W'(py_q);
		tx  = {px_q, 1'b1};
		ty  = (py_q == '0) ? PT_W'(1) : py_q - PT_W'(1);
		a_op = '0;
		b_op = '0;
		unique case (op_q)
			OP_AA: begin
				a_op = SQ_W'(a0_q);
				b_op = B_W'(a0_q);
			end
			OP_BB: begin
				a_op = SQ_W'(py_q);
				b_op = bpy;
			end
			OP_AB: begin
				a_op = aa_q;
				b_op = bpy;
			end
			OP_T1L: begin
				a_op = bb_q;
				b_op = bpx + B_W'(1);
			end
			OP_T1R: begin
				a_op = aa_q;
				b_op = (bpy << 1) - B_W'(1);
			end
			OP_R1X: begin
				a_op = bb_q;
				b_op = (bpx << 1) + B_W'(3);
			end
			OP_R1Y: begin
				a_op = aa_q;
				b_op = B_W'(2) - (bpy << 1);
			end
			OP_TX: begin
				a_op = SQ_W'(tx);
				b_op = B_W'(tx);
			end
			OP_E1: begin
				a_op = bb_q;
				b_op = B_W'(t_q);
			end
			OP_TY: begin
				a_op = SQ_W'(ty);
				b_op = B_W'(ty);
			end
			OP_E2: begin
				a_op = aa_q;
				b_op = B_W'(t_q);
			end
			OP_E3: begin
				a_op = aa_q;
				b_op = B_W'(bb_q);
			end
			OP_R2Y: begin
				a_op = aa_q;
				b_op = B_W'(3) - (bpy << 1);
			end
			OP_R2X: begin
				a_op = bb_q;
				b_op = (bpx << 1) + B_W'(2);
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_IDLE;
			op_q    <= OP_AA;
			mode_q  <= EM_FOUR;
			px_q    <= '0;
			py_q    <= '0;
			dec_q   <= '0;
			t_q     <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			a0_q    <= '0;
			aa_q    <= '0;
			bb_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cmd == CMD_START) begin
							cx_q    <= cx_in;
							cy_q    <= cy_in;
							a0_q    <= ax_in;
							py_q    <= PT_W'(ay_in);
							px_q    <= '0;
							phase_q <= PH_R1;
							op_q    <= OP_AA;
							state_q <= S_MUL;
						end else begin
							unique case (phase_q)
								PH_R1: begin
									op_q    <= OP_T1L;
									state_q <= S_MUL;
								end
								PH_R2: begin
									if (py_q == '0) begin
										mode_q  <= EM_HORIZ;
										phase_q <= PH_IDLE;
										state_q <= S_HAND;
									end else begin
										op_q    <= OP_R2Y;
										state_q <= S_MUL;
									end
								end
								default: begin
									// step with no ellipse open: no pixels
									state_q <= S_IDLE;
								end
							endcase
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					unique case (op_q)
						OP_AA: begin
							aa_q    <= p_dec[SQ_W-1:0];
							op_q    <= OP_BB;
							state_q <= S_MUL;
						end
						OP_BB: begin
							bb_q    <= p_dec[SQ_W-1:0];
							dec_q   <= p4 + DEC_W'(aa_q);
							op_q    <= OP_AB;
							state_q <= S_MUL;
						end
						OP_AB: begin
							dec_q   <= dec_q - p4;
							mode_q  <= EM_VERT;
							state_q <= S_HAND;
						end
						OP_T1L: begin
							t_q     <= {p_dec[DEC_W-2:0], 1'b0};
							op_q    <= OP_T1R;
							state_q <= S_MUL;
						end
						OP_T1R: begin
							if (py_q != '0 && t_q < p_dec) begin
								op_q <= OP_R1X;
							end else begin
								op_q <= OP_TX;
							end
							state_q <= S_MUL;
						end
						OP_R1X: begin
							dec_q <= dec_q + p4;
							px_q  <= px_q + PT_W'(1);
							if (!dec_neg) begin
								op_q    <= OP_R1Y;
								state_q <= S_MUL;
							end else begin
								mode_q  <= EM_FOUR;
								state_q <= S_HAND;
							end
						end
						OP_R1Y: begin
							dec_q   <= dec_q + p4;
							py_q    <= py_q - PT_W'(1);
							mode_q  <= EM_FOUR;
							state_q <= S_HAND;
						end
						OP_TX: begin
							t_q     <= p_dec;
							op_q    <= OP_E1;
							state_q <= S_MUL;
						end
						OP_E1: begin
							dec_q   <= p_dec;
							op_q    <= OP_TY;
							state_q <= S_MUL;
						end
						OP_TY: begin
							t_q     <= p_dec;
							op_q    <= OP_E2;
							state_q <= S_MUL;
						end
						OP_E2: begin
							dec_q   <= dec_q + p4;
							op_q    <= OP_E3;
							state_q <= S_MUL;
						end
						OP_E3: begin
							dec_q <= dec_q - p4;
							if (py_q == '0) begin
								mode_q  <= EM_HORIZ;
								phase_q <= PH_IDLE;
								state_q <= S_HAND;
							end else begin
								phase_q <= PH_R2;
								op_q    <= OP_R2Y;
								state_q <= S_MUL;
							end
						end
						OP_R2Y: begin
							// sign test uses the decision before this update
							dec_q <= dec_q + p4;
							py_q  <= py_q - PT_W'(1);
							if (dec_neg) begin
								op_q    <= OP_R2X;
								state_q <= S_MUL;
							end else begin
								mode_q  <= EM_FOUR;
								state_q <= S_HAND;
							end
						end
						OP_R2X: begin
							dec_q   <= dec_q + p4;
							px_q    <= px_q + PT_W'(1);
							mode_q  <= EM_FOUR;
							state_q <= S_HAND;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_HAND: begin
					if (!emit_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hand-off to the pixel emitter
	assign in_ready      = (state_q == S_IDLE);
	assign emit_ctl.load = (state_q == S_HAND) && !emit_busy;
	assign emit_ctl.mode = mode_q;
	assign cx            = cx_q;
	assign cy            = cy_q;
	assign ox            = px_q;
	assign oy            = py_q;

endmodule

// ----- rtl/mer_emit.sv -----
// ----------------------------------------------------------------------------
// Pixel emitter
// Holds one pixel set and streams its two or four mirror pixels, one per
// output transaction.
// ----------------------------------------------------------------------------
module mer_emit #(
	parameter int COORD_BITS = 12,
	parameter int PT_W       = 12
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mer_pkg::emit_ctl_t             ctl,
	input  logic [COORD_BITS-1:0]          cx,
	input  logic [COORD_BITS-1:0]          cy,
	input  logic [PT_W-1:0]                ox,
	input  logic [PT_W-1:0]                oy,
	input  logic [mer_pkg::COLOR_W-1:0]    color,
	output logic                           busy,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [mer_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	output logic                           m_axis_tlast,
	output logic                           m_axis_tuser
);
	import mer_pkg::*;

	localparam int SUM_W0 = (COORD_BITS > PT_W) ? COORD_BITS : PT_W;
	localparam int SUM_W  = (SUM_W0 > PIX_W) ? SUM_W0 : PIX_W;

	logic                  busy_q;
	logic [1:0]            idx_q;
	mode_t                 mode_q;
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [PT_W-1:0]       ox_q;
	logic [PT_W-1:0]       oy_q;

	logic [1:0]       last_idx;
	logic             is_last;
	logic             neg_x;
	logic             neg_y;
	logic [SUM_W-1:0] sum_x;
	logic [SUM_W-1:0] sum_y;

	// mirror selection for the current pixel
	always_comb begin
		last_idx = (mode_q == EM_FOUR) ? 2'd3 : 2'd1;
		is_last  = (idx_q == last_idx);
		unique case (mode_q)
			EM_FOUR: begin
				neg_x = idx_q[0];
				neg_y = idx_q[1];
			end
			EM_VERT: begin
				neg_x = 1'b0;
				neg_y = idx_q[0];
			end
			EM_HORIZ: begin
				neg_x = idx_q[0];
				neg_y = 1'b0;
			end
			default: begin
				neg_x = 1'b0;
				neg_y = 1'b0;
			end
		endcase
		sum_x = neg_x ? SUM_W'(cx_q) - SUM_W'(ox_q) : SUM_W'(cx_q) + SUM_W'(ox_q);
		sum_y = neg_y ? SUM_W'(cy_q) - SUM_W'(oy_q) : SUM_W'(cy_q) + SUM_W'(oy_q);
	end

	// set register and pixel counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			mode_q <= EM_FOUR;
			cx_q   <= '0;
			cy_q   <= '0;
			ox_q   <= '0;
			oy_q   <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			mode_q <= ctl.mode;
			cx_q   <= cx;
			cy_q   <= cy;
			ox_q   <= ox;
			oy_q   <= oy;
		end else if (busy_q && m_axis_tready) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	assign busy          = busy_q;
	assign m_axis_tvalid = busy_q;
	assign m_axis_tdata  = M_TDATA_W'({color, sum_y[PIX_W-1:0], sum_x[PIX_W-1:0]});
	assign m_axis_tlast  = is_last;
	assign m_axis_tuser  = (mode_q == EM_HORIZ) && is_last;

endmodule

// ----- rtl/mer_checker.sv -----
// ----------------------------------------------------------------------------
// Rasterizer port checker
// Port-level assertions on the stream sides, bound to the top level.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_rasterizer_top_assert.svh"

module mer_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic                           s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [mer_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  logic                           m_axis_tlast,
	input  logic                           m_axis_tuser
);
	import mer_pkg::*;

	// the ellipse-done pixel always closes its transaction's pixel set
	`MER_ASSERT_IMP(a_done_is_last, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "done pixel without last")

	// a stalled pixel holds
	`MER_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled pixel changed")

	// a start keeps the multiplier busy, so the input closes next cycle
	`MER_ASSERT_NXT(a_start_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_START), !s_axis_tready, "ready right after a start")

	// after the last pixel of a set, m_axis_tvalid is low in the next cycle before any reload
	`MER_ASSERT_NXT(a_set_gap, clk, arst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid, "pixel set reloaded without gap")

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
